@@ src/pfl_pkg.sv @@
// ----------------------------------------------------------------------------
// pfl_pkg
// Shared types and constants of the page free list allocator.
// ----------------------------------------------------------------------------
package pfl_pkg;

  localparam int NUM_PAGES = 4096;
  localparam int PAGE_W    = $clog2(NUM_PAGES);
  localparam int LINK_W    = PAGE_W + 1;
  localparam int COUNT_W   = 13;
  localparam int REF_W     = 16;
  localparam int OP_W      = 2;
  localparam int STATUS_W  = 2;
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 3;

  typedef logic [OP_W-1:0]     op_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [PAGE_W-1:0]   page_t;
  typedef logic [LINK_W-1:0]   link_t;
  typedef logic [COUNT_W-1:0]  count_t;
  typedef logic [REF_W-1:0]    ref_t;

  localparam link_t  LINK_NULL = link_t'(NUM_PAGES);
  localparam count_t COUNT_MAX = '1;

  localparam op_t OP_SEED  = 2'd0;
  localparam op_t OP_ALLOC = 2'd1;
  localparam op_t OP_FREE  = 2'd2;

  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_EMPTY  = 2'd1;
  localparam status_t ST_REJECT = 2'd2;
  localparam status_t ST_RANGE  = 2'd3;

  localparam logic REG_PAGE_COUNT = 1'b0;
  localparam count_t PAGE_COUNT_RESET = count_t'(NUM_PAGES);

endpackage

@@ src/pfl_if.sv @@
// ----------------------------------------------------------------------------
// pfl_if
// Request and result channels of the page free list allocator.
// ----------------------------------------------------------------------------
interface pfl_in_if import pfl_pkg::*; ();
  logic  valid;
  logic  ready;
  op_t   operation;
  page_t page_index;
  ref_t  page_ref;

  modport source (output valid, output operation, output page_index, output page_ref,
                  input ready);
  modport sink (input valid, input operation, input page_index, input page_ref,
                output ready);
endinterface

interface pfl_out_if import pfl_pkg::*; ();
  logic    valid;
  logic    ready;
  status_t status;
  page_t   granted_page;
  count_t  pages_free;

  modport source (output valid, output status, output granted_page, output pages_free,
                  input ready);
  modport sink (input valid, input status, input granted_page, input pages_free,
                output ready);
endinterface

@@ src/page_free_list_allocator.sv @@
// ----------------------------------------------------------------------------
// page_free_list_allocator
// Page frame allocator that keeps its free pages as a linked LIFO stack: a
// head register and one link entry per page in a synchronous memory. After
// reset the link memory is cleared to null, one entry per cycle; no request
// is taken in that time, configuration writes are. In the idle state a
// request is taken and the link entry of the head page (allocate) or of the
// given page (free) is read; the execute state, held while the last result
// is not yet taken, updates the entry, the head and the free count and loads
// the result register. The next request is accepted in the cycle after that.
// ----------------------------------------------------------------------------
module page_free_list_allocator import pfl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  pfl_in_if.sink            in_ch,
  pfl_out_if.source         out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [APB_AW-1:0] cfg_paddr,
  input  logic [APB_DW-1:0] cfg_pwdata,
  output logic [APB_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [1:0] state_r, state_nxt;
  page_t      clr_r, clr_nxt;
  link_t      head_r, head_nxt;
  count_t     count_r, count_nxt;
  count_t     page_count_r, page_count_nxt;

  op_t        op_r;
  page_t      idx_r;
  ref_t       ref_r;

  link_t      link_mem [NUM_PAGES];
  link_t      rd_data_r;
  page_t      rd_addr;
  logic       wr_en;
  page_t      wr_addr;
  link_t      wr_data;

  logic       out_valid_r, out_valid_nxt;
  status_t    status_r, status_nxt;
  page_t      granted_r, granted_nxt;
  count_t     pages_free_r;

  logic       in_accept;
  logic       out_free;
  logic       exec_go;
  logic       cfg_write;

  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == REG_PAGE_COUNT) ?
                      APB_DW'(page_count_r) : '0;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign exec_go     = (state_r == S_EXEC) && out_free;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = status_r;
  assign out_ch.granted_page = granted_r;
  assign out_ch.pages_free   = pages_free_r;

  always_comb begin
    if (state_r == S_IDLE) begin
      rd_addr = (in_ch.operation == OP_ALLOC) ? head_r[PAGE_W-1:0] : in_ch.page_index;
    end else begin
      rd_addr = (op_r == OP_ALLOC) ? head_r[PAGE_W-1:0] : idx_r;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= link_mem[rd_addr];
    if (wr_en) begin
      link_mem[wr_addr] <= wr_data;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    page_count_nxt = page_count_r;
    wr_en          = 1'b0;
    wr_addr        = idx_r;
    wr_data        = LINK_NULL;
    status_nxt     = status_r;
    granted_nxt    = granted_r;
    out_valid_nxt  = out_ch.ready ? 1'b0 : out_valid_r;

    if (cfg_write && cfg_paddr[2] == REG_PAGE_COUNT) begin
      page_count_nxt = cfg_pwdata[COUNT_W-1:0];
    end

    unique case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_go) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          status_nxt    = ST_OK;
          granted_nxt   = '0;
          case (op_r)
            OP_SEED: begin
              if (COUNT_W'(idx_r) >= page_count_r) begin
                status_nxt = ST_RANGE;
              end else begin
                wr_en    = 1'b1;
                wr_addr  = idx_r;
                wr_data  = head_r;
                head_nxt = LINK_W'(idx_r);
                if (count_r != COUNT_MAX) begin
                  count_nxt = count_r + 1'b1;
                end
              end
            end
            OP_ALLOC: begin
              if (head_r >= LINK_NULL) begin
                head_nxt   = LINK_NULL;
                status_nxt = ST_EMPTY;
              end else begin
                wr_en       = 1'b1;
                wr_addr     = head_r[PAGE_W-1:0];
                wr_data     = LINK_NULL;
                head_nxt    = (rd_data_r >= LINK_NULL) ? LINK_NULL : rd_data_r;
                granted_nxt = head_r[PAGE_W-1:0];
                if (count_r != '0) begin
                  count_nxt = count_r - 1'b1;
                end
              end
            end
            OP_FREE: begin
              if (ref_r != '0 || rd_data_r < LINK_NULL) begin
                status_nxt = ST_REJECT;
              end else begin
                wr_en    = 1'b1;
                wr_addr  = idx_r;
                wr_data  = head_r;
                head_nxt = LINK_W'(idx_r);
                if (count_r != COUNT_MAX) begin
                  count_nxt = count_r + 1'b1;
                end
              end
            end
            default: begin
              status_nxt = ST_OK;
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_r        <= '0;
      head_r       <= LINK_NULL;
      count_r      <= '0;
      page_count_r <= PAGE_COUNT_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      head_r       <= head_nxt;
      count_r      <= count_nxt;
      page_count_r <= page_count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r  <= in_ch.operation;
      idx_r <= in_ch.page_index;
      ref_r <= in_ch.page_ref;
    end
    status_r  <= status_nxt;
    granted_r <= granted_nxt;
    if (exec_go) begin
      pages_free_r <= count_nxt;
    end
  end

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_accept)
    else $error("request accepted while the link memory is being cleared");

  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == S_EXEC))
    else $error("accepted request did not enter the execute cycle");

  a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EXEC))
    else $error("result appeared without an execute cycle");

  a_head_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= LINK_NULL)
    else $error("list head holds a value beyond the null code");

endmodule
